// ----- hdl/sbca_pkg.sv -----
`timescale 1ns / 1ps

package sbca_pkg;

    localparam int OP_W    = 2;
    localparam int IN_W    = 32;
    localparam int TOTAL_W = 36;
    localparam int RECV_W  = 48;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_OVERHEAD = 2'd0;
    localparam logic [OP_W-1:0] OP_PAYLOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_CONSUME  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVER_READ = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] STAT_ZERO      = 2'd3;

    typedef struct packed {
        logic capture;
        logic decode;
        logic walk_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic consume_go;
        logic walk_done;
        logic out_free;
    } t_sts;

endpackage

// ----- hdl/sbca_ctrl.sv -----
`timescale 1ns / 1ps

module sbca_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sbca_pkg::t_sts i_sts,
    output sbca_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_sts.consume_go ? S_FETCH : S_RESULT;
            end
            S_FETCH: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.walk_step = 1'b1;
                n_state         = i_sts.walk_done ? S_RESULT : S_FETCH;
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/sbca_dp.sv -----
`timescale 1ns / 1ps

module sbca_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sbca_pkg::OP_W-1:0]        i_op,
    input  logic [sbca_pkg::IN_W-1:0]        i_byte_count,
    input  sbca_pkg::t_cmd                   i_cmd,
    output sbca_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_valid,
    output logic                             o_release_valid,
    output logic [sbca_pkg::TOTAL_W-1:0]     o_released_bytes,
    output logic [sbca_pkg::STAT_W-1:0]      o_status,
    output logic [sbca_pkg::TOTAL_W-1:0]     o_readable_bytes,
    output logic [sbca_pkg::RECV_W-1:0]      o_received_bytes
);

    localparam int LW = (LENGTH_BITS < sbca_pkg::IN_W) ? LENGTH_BITS : sbca_pkg::IN_W;
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int TW = sbca_pkg::TOTAL_W;

    logic [LW-1:0] r_mem_len [QUEUE_DEPTH];
    logic          r_mem_ovh [QUEUE_DEPTH];

    logic [sbca_pkg::OP_W-1:0]   r_op;
    logic [LW-1:0]               r_len;
    logic [AW-1:0]               r_head, n_head;
    logic [CW-1:0]               r_count, n_count;
    logic [TW-1:0]               r_readable, n_readable;
    logic [sbca_pkg::RECV_W-1:0] r_received, n_received;
    logic [LW-1:0]               r_rem;
    logic [TW-1:0]               r_rel;
    logic                        r_res_valid;
    logic [sbca_pkg::STAT_W-1:0] r_res_status;
    logic [LW-1:0]               r_rd_len;
    logic                        r_rd_ovh;
    logic                        r_out_valid;

    logic [TW-1:0] w_len36;
    logic          w_empty;
    logic          w_full;
    logic [AW:0]   w_tail_sum;
    logic [AW-1:0] w_tail;
    logic [AW-1:0] w_head_inc;
    logic [TW:0]   w_read_sum;
    logic          w_consume_ok;
    logic          w_zero;

    logic          d_push;
    logic          d_push_ovh;
    logic          d_payload;
    logic          d_valid;
    logic [sbca_pkg::STAT_W-1:0] d_status;

    logic          w_pop;
    logic          w_split;
    logic [LW-1:0] w_add_src;
    logic [TW:0]   w_rel_sum;
    logic [TW-1:0] w_rel_sat;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wlen;

    assign w_len36      = TW'(r_len);
    assign w_empty      = (r_count == '0);
    assign w_full       = (r_count >= CW'(QUEUE_DEPTH));
    assign w_tail_sum   = (AW+1)'(r_head) + (AW+1)'(r_count);
    assign w_tail       = (w_tail_sum >= (AW+1)'(QUEUE_DEPTH))
                        ? w_tail_sum[AW-1:0] - AW'(QUEUE_DEPTH)
                        : w_tail_sum[AW-1:0];
    assign w_head_inc   = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign w_read_sum   = {1'b0, r_readable} + {1'b0, w_len36};
    assign w_consume_ok = (w_len36 <= r_readable);
    assign w_zero       = (r_len == '0) && (r_op != sbca_pkg::OP_UNUSED);

    always_comb begin
        d_push     = 1'b0;
        d_push_ovh = 1'b0;
        d_payload  = 1'b0;
        d_valid    = 1'b0;
        d_status   = sbca_pkg::STAT_OK;
        if (w_zero) begin
            d_status = sbca_pkg::STAT_ZERO;
        end else begin
            case (r_op)
                sbca_pkg::OP_OVERHEAD: begin
                    if (w_empty) begin
                        d_valid = 1'b1;
                    end else if (w_full) begin
                        d_status = sbca_pkg::STAT_FULL;
                    end else begin
                        d_push     = 1'b1;
                        d_push_ovh = 1'b1;
                    end
                end
                sbca_pkg::OP_PAYLOAD: begin
                    if (w_full || w_read_sum[TW]) begin
                        d_status = sbca_pkg::STAT_FULL;
                    end else begin
                        d_push    = 1'b1;
                        d_payload = 1'b1;
                    end
                end
                sbca_pkg::OP_CONSUME: begin
                    if (w_consume_ok) begin
                        d_valid = 1'b1;
                    end else begin
                        d_status = sbca_pkg::STAT_OVER_READ;
                    end
                end
                default: begin
                    d_status = sbca_pkg::STAT_OK;
                end
            endcase
        end
    end

    assign o_sts.consume_go = (r_op == sbca_pkg::OP_CONSUME) && !w_zero && w_consume_ok;
    assign o_sts.walk_done  = w_empty || (!r_rd_ovh && ((r_rem == '0) || (r_rd_len > r_rem)));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign w_pop     = !w_empty && (r_rd_ovh || ((r_rem != '0) && (r_rd_len <= r_rem)));
    assign w_split   = !w_empty && !r_rd_ovh && (r_rem != '0) && (r_rd_len > r_rem);
    assign w_add_src = (r_rd_ovh || (r_rd_len <= r_rem)) ? r_rd_len : r_rem;
    assign w_rel_sum = {1'b0, r_rel} + (TW+1)'(w_add_src);
    assign w_rel_sat = w_rel_sum[TW] ? '1 : w_rel_sum[TW-1:0];

    assign w_we    = (i_cmd.decode && d_push) || (i_cmd.walk_step && w_split);
    assign w_waddr = i_cmd.decode ? w_tail : r_head;
    assign w_wlen  = i_cmd.decode ? r_len : r_rd_len - r_rem;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_len[w_waddr] <= w_wlen;
            if (i_cmd.decode) begin
                r_mem_ovh[w_waddr] <= d_push_ovh;
            end
        end
        r_rd_len <= r_mem_len[r_head];
        r_rd_ovh <= r_mem_ovh[r_head];
    end

    always_comb begin
        n_head     = r_head;
        n_count    = r_count;
        n_readable = r_readable;
        n_received = r_received;
        if (i_cmd.decode) begin
            if (d_push) begin
                n_count = r_count + CW'(1);
            end
            if (d_payload) begin
                n_readable = w_read_sum[TW-1:0];
                n_received = r_received + sbca_pkg::RECV_W'(r_len);
            end
            if (o_sts.consume_go) begin
                n_readable = r_readable - w_len36;
            end
        end
        if (i_cmd.walk_step && w_pop) begin
            n_head  = w_head_inc;
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_readable  <= '0;
            r_received  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_count    <= n_count;
            r_readable <= n_readable;
            r_received <= n_received;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_len <= i_byte_count[LW-1:0];
        end
        if (i_cmd.decode) begin
            r_res_valid  <= d_valid;
            r_res_status <= d_status;
            r_rem        <= r_len;
            r_rel        <= (r_op == sbca_pkg::OP_OVERHEAD && d_valid) ? w_len36 : '0;
        end
        if (i_cmd.walk_step && (w_pop || w_split)) begin
            r_rel <= w_rel_sat;
            if (!r_rd_ovh) begin
                r_rem <= r_rem - w_add_src;
            end
        end
        if (i_cmd.emit) begin
            o_release_valid  <= r_res_valid;
            o_released_bytes <= r_rel;
            o_status         <= r_res_status;
            o_readable_bytes <= r_readable;
            o_received_bytes <= r_received;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- hdl/stream_body_consume_accounting.sv -----
`timescale 1ns / 1ps

// Keeps a queue of stream fragments and reports, for every input transfer, one result
// transfer with the bytes released for flow control, a status and the running totals.
// An input transfer is taken only while the block is idle; the result is held in an
// output register, so the next transfer can be taken while a result still waits.
// Overhead, payload, unused, zero-length and refused events pass from decode to the result
// state. A consume event walks the queue through a single registered memory read port, with
// a fetch and an evaluate state per entry examined, up to QUEUE_DEPTH entries. The queue
// contents are undefined after reset; only the head, count, totals and result valid flag
// are cleared.
module stream_body_consume_accounting #(
    parameter int QUEUE_DEPTH = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [sbca_pkg::OP_W-1:0]        i_op,
    input  logic [sbca_pkg::IN_W-1:0]        i_byte_count,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_release_valid,
    output logic [sbca_pkg::TOTAL_W-1:0]     o_released_bytes,
    output logic [sbca_pkg::STAT_W-1:0]      o_status,
    output logic [sbca_pkg::TOTAL_W-1:0]     o_readable_bytes,
    output logic [sbca_pkg::RECV_W-1:0]      o_received_bytes
);

    sbca_pkg::t_cmd w_cmd;
    sbca_pkg::t_sts w_sts;

    sbca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sbca_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (i_op),
        .i_byte_count     (i_byte_count),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_out_ready      (i_ready),
        .o_valid          (o_valid),
        .o_release_valid  (o_release_valid),
        .o_released_bytes (o_released_bytes),
        .o_status         (o_status),
        .o_readable_bytes (o_readable_bytes),
        .o_received_bytes (o_received_bytes)
    );

endmodule

// ----- hdl/sbca_checker.sv -----
`timescale 1ns / 1ps

module sbca_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_release_valid,
    input logic [sbca_pkg::TOTAL_W-1:0] o_released_bytes,
    input logic [sbca_pkg::STAT_W-1:0]  o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_released_bytes) && $stable(o_status))
        else $error("result changed while stalled");

    a_fail_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != sbca_pkg::STAT_OK) |-> !o_release_valid)
        else $error("release issued with a failing status");

    a_no_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_release_valid |-> (o_released_bytes == '0))
        else $error("released bytes nonzero without a release");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind stream_body_consume_accounting sbca_checker u_sbca_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_release_valid  (o_release_valid),
    .o_released_bytes (o_released_bytes),
    .o_status         (o_status)
);

// ----- test/sbca_release_checker.sv -----
`timescale 1ns / 1ps

module sbca_release_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [sbca_pkg::OP_W-1:0]           i_op,
    input  logic [sbca_pkg::IN_W-1:0]           i_byte_count,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_release_valid,
    input  logic [sbca_pkg::TOTAL_W-1:0]        i_released_bytes,
    input  logic [sbca_pkg::STAT_W-1:0]         i_status,
    input  logic [sbca_pkg::TOTAL_W-1:0]        i_readable_bytes,
    input  logic [sbca_pkg::RECV_W-1:0]         i_received_bytes,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int               TW        = sbca_pkg::TOTAL_W;
    localparam int               RW        = sbca_pkg::RECV_W;
    localparam int               IW        = sbca_pkg::IN_W;
    localparam logic [TW-1:0]    TOTAL_MAX = '1;

    typedef struct packed {
        logic                          release_valid;
        logic [TW-1:0]                 released;
        logic [sbca_pkg::STAT_W-1:0]   status;
        logic [TW-1:0]                 readable;
        logic [RW-1:0]                 received;
    } t_release_report;

    logic [IW-1:0]  frag_len [QUEUE_DEPTH];
    logic           frag_overhead [QUEUE_DEPTH];
    int unsigned    queue_head;
    int unsigned    queue_fill;
    logic [TW-1:0]  readable_sum;
    logic [RW-1:0]  received_sum;
    int             fails = 0;

    t_release_report expected_reports [$];

    function automatic logic [TW-1:0] add_saturated(input logic [TW-1:0] a,
                                                    input logic [TW-1:0] b);
        logic [TW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TW] ? TOTAL_MAX : sum[TW-1:0];
    endfunction

    function automatic void enqueue_fragment(input logic [IW-1:0] len, input logic overhead);
        int unsigned slot;
        slot = (queue_head + queue_fill) % QUEUE_DEPTH;
        frag_len[slot]      = len;
        frag_overhead[slot] = overhead;
        queue_fill++;
    endfunction

    function automatic void dequeue_fragment();
        queue_head = (queue_head + 1) % QUEUE_DEPTH;
        queue_fill--;
    endfunction

    function automatic t_release_report predict_release(input logic [sbca_pkg::OP_W-1:0] op,
                                                        input logic [IW-1:0] len);
        t_release_report rep;
        logic [TW-1:0]   left;
        logic [TW-1:0]   freed;
        int unsigned     idx;
        rep        = '0;
        rep.status = sbca_pkg::STAT_OK;
        if ((op inside {sbca_pkg::OP_OVERHEAD, sbca_pkg::OP_PAYLOAD, sbca_pkg::OP_CONSUME})
                && len == '0) begin
            rep.status = sbca_pkg::STAT_ZERO;
        end else if (op == sbca_pkg::OP_OVERHEAD) begin
            if (queue_fill == 0) begin
                rep.release_valid = 1'b1;
                rep.released      = TW'(len);
            end else if (queue_fill >= QUEUE_DEPTH) begin
                rep.status = sbca_pkg::STAT_FULL;
            end else begin
                enqueue_fragment(len, 1'b1);
            end
        end else if (op == sbca_pkg::OP_PAYLOAD) begin
            if (queue_fill >= QUEUE_DEPTH || TW'(len) > TOTAL_MAX - readable_sum) begin
                rep.status = sbca_pkg::STAT_FULL;
            end else begin
                enqueue_fragment(len, 1'b0);
                readable_sum = readable_sum + TW'(len);
                received_sum = received_sum + RW'(len);
            end
        end else if (op == sbca_pkg::OP_CONSUME) begin
            if (TW'(len) > readable_sum) begin
                rep.status = sbca_pkg::STAT_OVER_READ;
            end else begin
                left  = TW'(len);
                freed = '0;
                while (queue_fill > 0) begin
                    idx = queue_head;
                    if (frag_overhead[idx]) begin
                        freed = add_saturated(freed, TW'(frag_len[idx]));
                        dequeue_fragment();
                    end else if (left == '0) begin
                        break;
                    end else if (TW'(frag_len[idx]) <= left) begin
                        freed = add_saturated(freed, TW'(frag_len[idx]));
                        left  = left - TW'(frag_len[idx]);
                        dequeue_fragment();
                    end else begin
                        freed         = add_saturated(freed, left);
                        frag_len[idx] = frag_len[idx] - left[IW-1:0];
                        left          = '0;
                        break;
                    end
                end
                readable_sum      = readable_sum - TW'(len);
                rep.release_valid = 1'b1;
                rep.released      = freed;
            end
        end
        rep.readable = readable_sum;
        rep.received = received_sum;
        return rep;
    endfunction

    function automatic void compare_field(input string what, input logic [RW-1:0] want,
                                          input logic [RW-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_release_report want;
        if (!i_rst_n) begin
            queue_head   = 0;
            queue_fill   = 0;
            readable_sum = '0;
            received_sum = '0;
            expected_reports.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_reports.insert(expected_reports.size(),
                                        predict_release(i_op, i_byte_count));
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with none expected, expected none, actual %h",
                             $time, i_released_bytes);
                end else begin
                    want = expected_reports[0];
                    expected_reports.delete(0);
                    compare_field("release_valid", RW'(want.release_valid),
                                  RW'(i_release_valid));
                    compare_field("released_bytes", RW'(want.released), RW'(i_released_bytes));
                    compare_field("status", RW'(want.status), RW'(i_status));
                    compare_field("readable_bytes", RW'(want.readable), RW'(i_readable_bytes));
                    compare_field("received_bytes", want.received, i_received_bytes);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_reports.size();
    end

endmodule

// ----- test/tb_stream_body_consume_accounting.sv -----
`timescale 1ns / 1ps

module tb_stream_body_consume_accounting;

    localparam int                        QUEUE_DEPTH  = 16;
    localparam int                        RANDOM_ITEMS = 1535;
    localparam int                        LIMIT_CYCLES = 1_000_000;
    localparam int                        HOLD_CYCLES  = 400;
    localparam int                        DRAIN_CYCLES = 60;
    localparam logic [sbca_pkg::IN_W-1:0] LEN_MAX      = '1;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [sbca_pkg::OP_W-1:0]         in_op = '0;
    logic [sbca_pkg::IN_W-1:0]         in_byte_count = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic                              release_valid;
    logic [sbca_pkg::TOTAL_W-1:0]      released_bytes;
    logic [sbca_pkg::STAT_W-1:0]       status;
    logic [sbca_pkg::TOTAL_W-1:0]      readable_bytes;
    logic [sbca_pkg::RECV_W-1:0]       received_bytes;
    int                                fail_count;
    int                                pending;

    int traffic_phase = 1;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int tx_gap_pct = 12;
    int cycle_count = 0;

    always #1 i_clk = ~i_clk;

    stream_body_consume_accounting #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LENGTH_BITS (sbca_pkg::IN_W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_op             (in_op),
        .i_byte_count     (in_byte_count),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_release_valid  (release_valid),
        .o_released_bytes (released_bytes),
        .o_status         (status),
        .o_readable_bytes (readable_bytes),
        .o_received_bytes (received_bytes)
    );

    sbca_release_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_op             (in_op),
        .i_byte_count     (in_byte_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_release_valid  (release_valid),
        .i_released_bytes (released_bytes),
        .i_status         (status),
        .i_readable_bytes (readable_bytes),
        .i_received_bytes (received_bytes),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver holds off for a long stretch once the last phase begins.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (traffic_phase == 3 && !hold_done) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_ready <= $urandom_range(99) >=
                         ((traffic_phase == 1) ? 81 : (traffic_phase == 2) ? 12 : 0);
        end
    end

    task automatic send_event(input logic [sbca_pkg::OP_W-1:0] op,
                              input logic [sbca_pkg::IN_W-1:0] len);
        while ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid      <= 1'b1;
        in_op         <= op;
        in_byte_count <= len;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic logic [sbca_pkg::IN_W-1:0] pick_length(input bit for_consume);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) return $urandom_range(1, for_consume ? 24 : 16);
        if (pick < 72) return $urandom_range(17, 4096);
        if (pick < 88) return $urandom;
        if (pick < 93) return LEN_MAX;
        if (pick < 96) return 1 << $urandom_range(sbca_pkg::IN_W - 1);
        return '0;
    endfunction

    function automatic logic [sbca_pkg::OP_W-1:0] pick_op(input int mode);
        int pick;
        int cut_overhead;
        int cut_payload;
        int cut_consume;
        pick = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                cut_overhead = 35; cut_payload = 93; cut_consume = 98;
            end
            MODE_DRAIN: begin
                cut_overhead = 15; cut_payload = 30; cut_consume = 97;
            end
            default: begin
                cut_overhead = 30; cut_payload = 63; cut_consume = 97;
            end
        endcase
        if (pick < cut_overhead) return sbca_pkg::OP_OVERHEAD;
        if (pick < cut_payload) return sbca_pkg::OP_PAYLOAD;
        if (pick < cut_consume) return sbca_pkg::OP_CONSUME;
        return sbca_pkg::OP_UNUSED;
    endfunction

    initial begin
        int                        mode;
        int                        burst_left;
        logic [sbca_pkg::OP_W-1:0] op;
        mode       = MODE_MIXED;
        burst_left = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_event(sbca_pkg::OP_OVERHEAD, '0);
        send_event(sbca_pkg::OP_PAYLOAD, '0);
        send_event(sbca_pkg::OP_CONSUME, '0);
        send_event(sbca_pkg::OP_UNUSED, LEN_MAX);
        send_event(sbca_pkg::OP_OVERHEAD, 32'd5);
        send_event(sbca_pkg::OP_OVERHEAD, LEN_MAX);
        send_event(sbca_pkg::OP_CONSUME, 32'd1);
        send_event(sbca_pkg::OP_PAYLOAD, LEN_MAX);
        send_event(sbca_pkg::OP_OVERHEAD, 32'd7);
        send_event(sbca_pkg::OP_PAYLOAD, 32'd10);
        send_event(sbca_pkg::OP_OVERHEAD, 32'd3);
        send_event(sbca_pkg::OP_CONSUME, LEN_MAX);
        send_event(sbca_pkg::OP_CONSUME, LEN_MAX);
        send_event(sbca_pkg::OP_CONSUME, 32'd4);
        send_event(sbca_pkg::OP_CONSUME, 32'd6);
        send_event(sbca_pkg::OP_PAYLOAD, 32'h8000_0001);
        send_event(sbca_pkg::OP_UNUSED, '0);
        send_event(sbca_pkg::OP_CONSUME, 32'h8000_0001);

        for (int phase = 1; phase <= 3; phase++) begin
            traffic_phase <= phase;
            tx_gap_pct = (phase == 1) ? 12 : (phase == 2) ? 81 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                if (burst_left == 0) begin
                    mode       = $urandom_range(MODE_MIXED);
                    burst_left = $urandom_range(8, 24);
                end
                burst_left--;
                op = pick_op(mode);
                send_event(op, pick_length(op == sbca_pkg::OP_CONSUME));
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- stream_body_consume_accounting.f -----
hdl/sbca_pkg.sv
hdl/sbca_ctrl.sv
hdl/sbca_dp.sv
hdl/stream_body_consume_accounting.sv
hdl/sbca_checker.sv
test/sbca_release_checker.sv
test/tb_stream_body_consume_accounting.sv
